>>> rtl/d2d_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and register indexes for the disparity to depth block
package d2d_pkg;

  localparam int COORD_BITS = 12;
  localparam int DISP_W     = 16;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int DEPTH_W    = 16;
  localparam int AD_W       = 15;
  localparam int DX_W       = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;
  localparam int PX_W       = DX_W + CFG_W;
  localparam int RZ_W       = CFG_W + AD_W;
  localparam int FB_W       = 2 * CFG_W;
  localparam int SUM_W      = FB_W + CFG_W;
  localparam int Q_SHIFT    = 44;
  localparam int Q_W        = SUM_W - Q_SHIFT;
  localparam int Z_SHIFT    = 12;
  localparam int QUOT_W     = DEPTH_W;
  localparam int DIV_STAGES = QUOT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASELINE     = 4'd0,
    REG_FOCAL_LENGTH = 4'd1,
    REG_PRINC_POINT  = 4'd2,
    REG_ROI_X        = 4'd3,
    REG_ROI_Y        = 4'd4,
    REG_ROI_Z        = 4'd5,
    REG_DEPTH_SCALE  = 4'd6,
    REG_MIN_DISP     = 4'd7
  } cfg_reg_t;

  localparam logic [CFG_W-1:0]  RST_BASELINE     = 32'd35389;
  localparam logic [CFG_W-1:0]  RST_FOCAL_LENGTH = 32'd47185920;
  localparam logic [CFG_W-1:0]  RST_PRINC_POINT  = 32'd0;
  localparam logic [CFG_W-1:0]  RST_ROI_X        = 32'd1310720;
  localparam logic [CFG_W-1:0]  RST_ROI_Y        = 32'd1310720;
  localparam logic [CFG_W-1:0]  RST_ROI_Z        = 32'd3276800;
  localparam logic [CFG_W-1:0]  RST_DEPTH_SCALE  = 32'd65536000;
  localparam logic [DISP_W-1:0] RST_MIN_DISP     = 16'hFFF0;

  typedef struct packed {
    logic [CFG_W-1:0]  baseline;
    logic [CFG_W-1:0]  focal_length;
    logic [CFG_W-1:0]  principal_point;
    logic [CFG_W-1:0]  roi_x;
    logic [CFG_W-1:0]  roi_y;
    logic [CFG_W-1:0]  roi_z;
    logic [CFG_W-1:0]  depth_scale;
    logic [DISP_W-1:0] min_disparity;
  } d2d_cfg_t;

  typedef struct packed {
    logic            ok;
    logic [AD_W-1:0] ad;
    logic [Q_W-1:0]  q;
  } front_t;

  typedef struct packed {
    logic              ok;
    logic              sat;
    logic [AD_W-1:0]   ad;
    logic [AD_W-1:0]   rem;
    logic [QUOT_W-1:0] low;
    logic [QUOT_W-1:0] quot;
  } div_t;

endpackage

>>> rtl/d2d_front.sv
`timescale 1ns / 1ps
// geometry, roi tests and depth numerator over three pipeline stages
module d2d_front import d2d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  d2d_cfg_t              cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DISP_W-1:0]     in_disparity,
  input  logic [COORD_BITS-1:0] in_column,
  input  logic [COORD_BITS-1:0] in_row,
  output logic                  out_valid,
  input  logic                  out_ready,
  output front_t                out_data
);

  logic rdy1, rdy2, rdy3;

  // stage 1
  logic             v1_r, rej1_r, rej1_nxt;
  logic [AD_W-1:0]  ad1_r;
  logic [DX_W-1:0]  dx1_r, dy1_r, dx1_nxt, dy1_nxt;
  logic [FB_W-1:0]  fb1_r, fb1_nxt;
  logic [DX_W-1:0]  u_ext, v_ext, cu_ext, cv_ext;

  // stage 2
  logic             v2_r, rej2_r, fbnz2_r;
  logic [PX_W-1:0]  px2_r, rx2_r, py2_r, ry2_r;
  logic [PX_W-1:0]  px2_nxt, rx2_nxt, py2_nxt, ry2_nxt;
  logic [RZ_W-1:0]  rz2_r, rz2_nxt;
  logic [FB_W-1:0]  fb2_r, pa2_r, pb2_r, pa2_nxt, pb2_nxt;
  logic [AD_W-1:0]  ad2_r;

  // stage 3
  logic             v3_r;
  front_t           d3_r, d3_nxt;
  logic [SUM_W-1:0] sum3;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    u_ext    = DX_W'({in_column, 4'b0000});
    v_ext    = DX_W'({in_row, 4'b0000});
    cu_ext   = DX_W'(cfg.principal_point[15:0]);
    cv_ext   = DX_W'(cfg.principal_point[31:16]);
    dx1_nxt  = (u_ext >= cu_ext) ? u_ext - cu_ext : cu_ext - u_ext;
    dy1_nxt  = (v_ext >= cv_ext) ? v_ext - cv_ext : cv_ext - v_ext;
    rej1_nxt = (in_disparity == '0) || (in_disparity == cfg.min_disparity)
               || in_disparity[DISP_W-1];
    fb1_nxt  = FB_W'(cfg.focal_length) * FB_W'(cfg.baseline);
  end

  always_comb begin
    px2_nxt = PX_W'(dx1_r) * PX_W'(cfg.baseline);
    py2_nxt = PX_W'(dy1_r) * PX_W'(cfg.baseline);
    rx2_nxt = PX_W'(cfg.roi_x) * PX_W'(ad1_r);
    ry2_nxt = PX_W'(cfg.roi_y) * PX_W'(ad1_r);
    rz2_nxt = RZ_W'(cfg.roi_z) * RZ_W'(ad1_r);
    pa2_nxt = FB_W'(fb1_r[CFG_W-1:0]) * FB_W'(cfg.depth_scale);
    pb2_nxt = FB_W'(fb1_r[FB_W-1:CFG_W]) * FB_W'(cfg.depth_scale);
  end

  always_comb begin
    sum3      = SUM_W'(pa2_r) + {pb2_r, {CFG_W{1'b0}}};
    d3_nxt.q  = sum3[SUM_W-1:Q_SHIFT];
    d3_nxt.ad = ad2_r;
    d3_nxt.ok = !rej2_r && fbnz2_r && (px2_r < rx2_r) && (py2_r < ry2_r)
                && (fb2_r < FB_W'({rz2_r, {Z_SHIFT{1'b0}}}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      rej1_r <= rej1_nxt;
      ad1_r  <= in_disparity[AD_W-1:0];
      dx1_r  <= dx1_nxt;
      dy1_r  <= dy1_nxt;
      fb1_r  <= fb1_nxt;
    end
    if (rdy2) begin
      rej2_r  <= rej1_r;
      fbnz2_r <= (fb1_r != '0);
      ad2_r   <= ad1_r;
      fb2_r   <= fb1_r;
      px2_r   <= px2_nxt;
      py2_r   <= py2_nxt;
      rx2_r   <= rx2_nxt;
      ry2_r   <= ry2_nxt;
      rz2_r   <= rz2_nxt;
      pa2_r   <= pa2_nxt;
      pb2_r   <= pb2_nxt;
    end
    if (rdy3) begin
      d3_r <= d3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = d3_r;

endmodule

>>> rtl/d2d_div_stage.sv
`timescale 1ns / 1ps
// one restoring division step with its pipeline register
module d2d_div_stage import d2d_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_data
);

  logic          v_r;
  div_t          d_r, d_nxt;
  logic [AD_W:0] trial;
  logic          ge;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    trial        = {in_data.rem, in_data.low[QUOT_W-1]};
    ge           = (trial >= {1'b0, in_data.ad});
    d_nxt        = in_data;
    d_nxt.rem    = ge ? AD_W'(trial - {1'b0, in_data.ad}) : trial[AD_W-1:0];
    d_nxt.low    = {in_data.low[QUOT_W-2:0], 1'b0};
    d_nxt.quot   = {in_data.quot[QUOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

>>> rtl/d2d_div.sv
`timescale 1ns / 1ps
// saturation check and pipelined divide of the depth numerator by disparity
module d2d_div import d2d_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  front_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output div_t   out_data
);

  logic v0_r, rdy0;
  div_t d0_r, d0_nxt;

  logic stg_v   [DIV_STAGES+1];
  logic stg_rdy [DIV_STAGES+1];
  div_t stg_d   [DIV_STAGES+1];

  assign rdy0     = !v0_r || stg_rdy[0];
  assign in_ready = rdy0;

  always_comb begin
    d0_nxt.ok   = in_data.ok;
    d0_nxt.sat  = (in_data.q >= Q_W'({in_data.ad, {QUOT_W{1'b0}}}));
    d0_nxt.ad   = in_data.ad;
    d0_nxt.rem  = in_data.q[AD_W+QUOT_W-1:QUOT_W];
    d0_nxt.low  = in_data.q[QUOT_W-1:0];
    d0_nxt.quot = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (rdy0) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      d0_r <= d0_nxt;
    end
  end

  assign stg_v[0] = v0_r;
  assign stg_d[0] = d0_r;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
    d2d_div_stage u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_v[k]),
      .in_ready  (stg_rdy[k]),
      .in_data   (stg_d[k]),
      .out_valid (stg_v[k+1]),
      .out_ready (stg_rdy[k+1]),
      .out_data  (stg_d[k+1])
    );
  end

  assign stg_rdy[DIV_STAGES] = out_ready;
  assign out_valid           = stg_v[DIV_STAGES];
  assign out_data            = stg_d[DIV_STAGES];

endmodule

>>> rtl/disparity_to_depth_roi.sv
`timescale 1ns / 1ps
// disparity to depth converter with roi gating, top level
// pipeline from request accepted to result valid, with its registers in order:
//   (3 geometry/multiply stages, 1 saturation stage, 16 divide steps, output register)
// throughput: one request per cycle when not stalled, set by the one-bit-per-stage divider
// reset: synchronous active-low rst_n empties the pipeline and loads register defaults
module disparity_to_depth_roi import d2d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DISP_W-1:0]     in_disparity,
  input  logic [COORD_BITS-1:0] in_column,
  input  logic [COORD_BITS-1:0] in_row,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DEPTH_W-1:0]    out_depth,
  output logic                  out_written
);

  d2d_cfg_t cfg_r;

  logic   front_ready, front_valid, div_ready, div_valid, out_rdy;
  front_t front_data;
  div_t   div_data;

  logic               out_valid_r, out_written_r;
  logic [DEPTH_W-1:0] out_depth_r, depth_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.baseline        <= RST_BASELINE;
      cfg_r.focal_length    <= RST_FOCAL_LENGTH;
      cfg_r.principal_point <= RST_PRINC_POINT;
      cfg_r.roi_x           <= RST_ROI_X;
      cfg_r.roi_y           <= RST_ROI_Y;
      cfg_r.roi_z           <= RST_ROI_Z;
      cfg_r.depth_scale     <= RST_DEPTH_SCALE;
      cfg_r.min_disparity   <= RST_MIN_DISP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_BASELINE:     cfg_r.baseline        <= cfg_wdata;
        REG_FOCAL_LENGTH: cfg_r.focal_length    <= cfg_wdata;
        REG_PRINC_POINT:  cfg_r.principal_point <= cfg_wdata;
        REG_ROI_X:        cfg_r.roi_x           <= cfg_wdata;
        REG_ROI_Y:        cfg_r.roi_y           <= cfg_wdata;
        REG_ROI_Z:        cfg_r.roi_z           <= cfg_wdata;
        REG_DEPTH_SCALE:  cfg_r.depth_scale     <= cfg_wdata;
        REG_MIN_DISP:     cfg_r.min_disparity   <= cfg_wdata[DISP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = !front_ready;

  d2d_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (front_ready),
    .in_disparity (in_disparity),
    .in_column    (in_column),
    .in_row       (in_row),
    .out_valid    (front_valid),
    .out_ready    (div_ready),
    .out_data     (front_data)
  );

  d2d_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_ready  (div_ready),
    .in_data   (front_data),
    .out_valid (div_valid),
    .out_ready (out_rdy),
    .out_data  (div_data)
  );

  // output register
  assign out_rdy = !out_valid_r || !out_stall;

  always_comb begin
    if (!div_data.ok) begin
      depth_nxt = '0;
    end else if (div_data.sat) begin
      depth_nxt = '1;
    end else begin
      depth_nxt = div_data.quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_depth_r   <= depth_nxt;
      out_written_r <= div_data.ok;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_depth   = out_depth_r;
  assign out_written = out_written_r;

endmodule

>>> test/disparity_to_depth_roi_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the disparity to depth converter with roi gating
module disparity_to_depth_roi_test;
  import d2d_pkg::*;

  localparam int LATENCY     = 21;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd12;

  typedef struct packed {
    logic [DISP_W-1:0]     disp;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               written;
  } depth_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [DISP_W-1:0]     in_disparity = '0;
  logic [COORD_BITS-1:0] in_column = '0;
  logic [COORD_BITS-1:0] in_row = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DEPTH_W-1:0]    out_depth;
  logic                  out_written;

  d2d_cfg_t   cfg_model;
  pixel_t     pixel_queue[$];
  depth_res_t depth_due[$];
  int         pixels_queued = 0;
  int         pixels_taken = 0;
  int         mismatches = 0;
  int         cycle_count = 0;
  int         burst_left = 1;
  int         gap_left = 0;
  int         hold_left = 0;
  int         mode_left = 0;
  int         stall_mode = 0;
  bit         long_hold_done = 1'b0;
  pixel_t     next_pixel;
  depth_res_t seen;

  disparity_to_depth_roi uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_disparity(in_disparity),
    .in_column   (in_column),
    .in_row      (in_row),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_depth   (out_depth),
    .out_written (out_written)
  );

  always #6 clk = ~clk;

  function automatic depth_res_t predict_depth(input d2d_cfg_t c,
                                               input logic [DISP_W-1:0] disp,
                                               input logic [COORD_BITS-1:0] col,
                                               input logic [COORD_BITS-1:0] row);
    depth_res_t       r;
    logic [DISP_W-1:0] mag16;
    logic [63:0]      mag, ux, vy, cu, cv, dx, dy, fb, quo;
    logic [95:0]      prod;
    logic             keep;
    r = '0;
    mag16 = disp[DISP_W-1] ? -disp : disp;
    mag = 64'(mag16);
    ux = 64'(col) << 4;
    vy = 64'(row) << 4;
    cu = 64'(c.principal_point[15:0]);
    cv = 64'(c.principal_point[31:16]);
    dx = (ux >= cu) ? ux - cu : cu - ux;
    dy = (vy >= cv) ? vy - cv : cv - vy;
    fb = 64'(c.focal_length) * 64'(c.baseline);
    keep = (dx * 64'(c.baseline) < 64'(c.roi_x) * mag) &&
           (dy * 64'(c.baseline) < 64'(c.roi_y) * mag) &&
           (fb < ((64'(c.roi_z) * mag) << Z_SHIFT)) &&
           !disp[DISP_W-1] && (fb != 64'd0);
    if (disp != '0 && disp != c.min_disparity && keep) begin
      prod = 96'(fb) * 96'(c.depth_scale);
      quo = 64'(prod >> Q_SHIFT) / mag;
      r.depth = (quo > 64'd65535) ? 16'hFFFF : quo[15:0];
      r.written = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [DISP_W-1:0] pick_disparity();
    logic [DISP_W-1:0] d;
    case ($urandom_range(0, 19))
      0, 1:               d = '0;
      2:                  d = cfg_model.min_disparity;
      3:                  d = cfg_model.min_disparity + DISP_W'($urandom_range(0, 2)) - 16'd1;
      4, 5:               d = -DISP_W'($urandom_range(1, 32768));
      6, 7:               d = DISP_W'($urandom_range(1, 64));
      16, 17:             d = DISP_W'($urandom_range(4096, 32767));
      18, 19:             d = DISP_W'($urandom);
      default:            d = DISP_W'($urandom_range(1, 4095));
    endcase
    return d;
  endfunction

  task automatic push_pixel(input logic [DISP_W-1:0] disp, input logic [COORD_BITS-1:0] col,
                            input logic [COORD_BITS-1:0] row);
    pixel_queue.insert(pixel_queue.size(), pixel_t'{disp: disp, col: col, row: row});
    pixels_queued++;
  endtask

  task automatic push_random(input int n);
    logic [COORD_BITS-1:0] col, row;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        col = COORD_BITS'(cfg_model.principal_point[15:4] + $urandom_range(0, 64) - 32);
        row = COORD_BITS'(cfg_model.principal_point[31:20] + $urandom_range(0, 64) - 32);
      end else begin
        col = COORD_BITS'($urandom);
        row = COORD_BITS'($urandom);
      end
      push_pixel(pick_disparity(), col, row);
    end
  endtask

  task automatic wait_idle();
    while (pixels_taken != pixels_queued || depth_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic push_chunks(input int n);
    int k;
    while (n > 0) begin
      k = $urandom_range(10, 60);
      if (k > n) k = n;
      push_random(k);
      n -= k;
      if ($urandom_range(0, 2) == 0) wait_idle();
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BASELINE:     cfg_model.baseline = data;
      REG_FOCAL_LENGTH: cfg_model.focal_length = data;
      REG_PRINC_POINT:  cfg_model.principal_point = data;
      REG_ROI_X:        cfg_model.roi_x = data;
      REG_ROI_Y:        cfg_model.roi_y = data;
      REG_ROI_Z:        cfg_model.roi_z = data;
      REG_DEPTH_SCALE:  cfg_model.depth_scale = data;
      REG_MIN_DISP:     cfg_model.min_disparity = data[DISP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_load(input logic [CFG_W-1:0] b, f, pp, rx, ry, rz, s, md);
    cfg_write(REG_BASELINE, b);
    cfg_write(REG_FOCAL_LENGTH, f);
    cfg_write(REG_PRINC_POINT, pp);
    cfg_write(REG_ROI_X, rx);
    cfg_write(REG_ROI_Y, ry);
    cfg_write(REG_ROI_Z, rz);
    cfg_write(REG_DEPTH_SCALE, s);
    cfg_write(REG_MIN_DISP, md);
  endtask

  initial begin
    cfg_model = '{baseline: RST_BASELINE, focal_length: RST_FOCAL_LENGTH,
                  principal_point: RST_PRINC_POINT, roi_x: RST_ROI_X, roi_y: RST_ROI_Y,
                  roi_z: RST_ROI_Z, depth_scale: RST_DEPTH_SCALE,
                  min_disparity: RST_MIN_DISP};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (LATENCY + 4) @(posedge clk);

    // defaults: zero, frame minimum, extremes, roi borders
    push_pixel(16'd0, 12'd0, 12'd0);
    push_pixel(-16'sd16, 12'd100, 12'd100);
    push_pixel(16'h8000, 12'd4095, 12'd4095);
    push_pixel(16'h7FFF, 12'd4095, 12'd4095);
    push_pixel(16'd1, 12'd0, 12'd0);
    push_pixel(-16'sd200, 12'd10, 12'd10);
    push_pixel(16'd200, 12'd0, 12'd0);
    push_pixel(16'd125, 12'd0, 12'd0);
    push_pixel(16'd124, 12'd0, 12'd0);
    push_pixel(16'd200, 12'd4095, 12'd0);
    push_pixel(16'd200, 12'd0, 12'd4095);
    push_pixel(16'd2000, 12'd4095, 12'd4095);
    push_pixel(-16'sd15, 12'd1, 12'd1);
    push_pixel(-16'sd17, 12'd1, 12'd1);
    push_pixel(16'h5555, 12'hAAA, 12'h555);
    push_random(120);
    wait_idle();

    // every register but the minimum disparity at its top value
    cfg_load('1, '1, '1, '1, '1, '1, '1, 32'h0000_8000);
    cfg_write(REG_UNUSED, 32'h1234_5678);
    push_pixel(16'h8000, 12'd2048, 12'd2048);
    push_pixel(16'h7FFF, 12'd4095, 12'd0);
    push_chunks(30);
    wait_idle();

    // every register cleared
    cfg_load('0, '0, '0, '0, '0, '0, '0, '0);
    push_pixel(16'd0, 12'd0, 12'd0);
    push_pixel(16'd500, 12'd0, 12'd0);
    push_chunks(30);
    wait_idle();

    // wide roi and huge scale so that depth saturates for small disparities
    cfg_load(RST_BASELINE, RST_FOCAL_LENGTH, {16'd5760, 16'd10240}, '1, '1, '1, '1,
             32'h0000_7FFF);
    push_pixel(16'd1, 12'd640, 12'd360);
    push_pixel(16'h7FFF, 12'd640, 12'd360);
    push_pixel(16'h7FFE, 12'd640, 12'd360);
    push_chunks(100);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      cfg_load($urandom_range(8000, 200000),
               $urandom_range(200, 2000) << 16,
               ($urandom_range(0, 3) == 0) ? $urandom : {16'($urandom_range(0, 12000)),
                                                         16'($urandom_range(0, 20000))},
               ($urandom_range(0, 4) == 0) ? $urandom : ($urandom_range(1, 100) << 16),
               ($urandom_range(0, 4) == 0) ? $urandom : ($urandom_range(1, 100) << 16),
               ($urandom_range(0, 4) == 0) ? $urandom : ($urandom_range(5, 300) << 16),
               ($urandom_range(0, 4) == 0) ? $urandom : ($urandom_range(1, 5000) << 16),
               $urandom);
      push_chunks(90);
      wait_idle();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        depth_due.insert(depth_due.size(),
                         predict_depth(cfg_model, in_disparity, in_column, in_row));
        pixels_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          next_pixel = pixel_queue.pop_front();
          in_valid <= 1'b1;
          in_disparity <= next_pixel.disp;
          in_column <= next_pixel.col;
          in_row <= next_pixel.row;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
            gap_left = $urandom_range(0, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (pixel_queue.size() > 60 &&
                 (!long_hold_done || $urandom_range(0, 999) == 0)) begin
      hold_left = 300;
      long_hold_done = 1'b1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left <= 0) begin
        mode_left = $urandom_range(20, 200);
        stall_mode = $urandom_range(0, 3);
      end
      mode_left--;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= cycle_count[2];
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (depth_due.size() == 0) begin
        $error("unexpected result: depth %0d written %0b", out_depth, out_written);
        mismatches++;
      end else begin
        seen = depth_due.pop_front();
        if (out_depth !== seen.depth) begin
          $error("depth: expected %0d, got %0d", seen.depth, out_depth);
          mismatches++;
        end
        if (out_written !== seen.written) begin
          $error("written: expected %0b, got %0b", seen.written, out_written);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
